// ----- src/srs_pkg.sv -----
// Shared definitions for the stable rank sort block.
// Field widths, the default capacity and the controller state type.
`default_nettype none

package srs_pkg;

   // Default number of elements held in one set
   localparam int MaxLenDefault = 32;

   // Payload widths fixed by the channel definitions
   localparam int ValueW  = 32;
   localparam int SrcIdxW = 5;

   // Top-level controller phases
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RANK,
      ST_EMIT
   } state_type;

endpackage : srs_pkg

`default_nettype wire

// ----- src/srs_req_if.sv -----
// Input channel of the stable rank sort block: one element per transfer.
// Depends on srs_pkg for the payload widths.
`default_nettype none

interface srs_req_if
   import srs_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic signed [ValueW-1:0] value;
   logic                     is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);

endinterface : srs_req_if

`default_nettype wire

// ----- src/srs_rsp_if.sv -----
// Result channel of the stable rank sort block: one source index per transfer.
// Depends on srs_pkg for the payload widths.
`default_nettype none

interface srs_rsp_if
   import srs_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic [SrcIdxW-1:0] source_index;
   logic               final_res;
   logic               overflow;

   modport source (output valid, output source_index, output final_res,
                   output overflow, input ready);
   modport sink   (input valid, input source_index, input final_res,
                   input overflow, output ready);

endinterface : srs_rsp_if

`default_nettype wire

// ----- src/srs_rank.sv -----
// Ranking engine: holds the element values in a synchronous memory and
// counts, for each pivot, the elements ordered before it. Depends on srs_pkg.
`default_nettype none

module srs_rank
   import srs_pkg::*;
#(
   parameter int MAX_LEN = MaxLenDefault
) (
   input  wire                      clock,
   input  wire                      reset,
   // element writes during load
   input  wire                      wr_en,
   input  wire [$clog2(MAX_LEN)-1:0] wr_addr,
   input  wire signed [ValueW-1:0]  wr_value,
   // ranking control
   input  wire                      start,
   input  wire [$clog2(MAX_LEN+1)-1:0] n,
   // order table write: entry at rank ord_addr gets index ord_idx
   output logic                     ord_we,
   output logic [$clog2(MAX_LEN)-1:0] ord_addr,
   output logic [$clog2(MAX_LEN)-1:0] ord_idx,
   output logic                     done
);

   localparam int IdxW = $clog2(MAX_LEN);
   localparam int CntW = $clog2(MAX_LEN+1);

   // Value memory: written only while loading, read only while ranking,
   // so the two ports never touch the same entry in the same phase.
   logic signed [ValueW-1:0] value_mem [MAX_LEN];
   logic signed [ValueW-1:0] rd_data_ff;
   logic [IdxW-1:0]          rd_addr;

   // issue side
   logic            busy_ff, busy_in;
   logic            iss_piv_ff, iss_piv_in;
   logic [IdxW-1:0] iss_i_ff, iss_i_in;
   logic [IdxW-1:0] iss_j_ff, iss_j_in;
   logic            j_last, i_last;

   // return side, aligned with rd_data_ff
   logic            ret_vld_ff;
   logic            ret_piv_ff;
   logic [IdxW-1:0] ret_i_ff;
   logic [IdxW-1:0] ret_j_ff;
   logic            ret_last_ff;
   logic            ret_done_ff;

   logic signed [ValueW-1:0] pivot_ff;
   logic [IdxW-1:0]          rank_ff;
   logic [IdxW-1:0]          rank_in;
   logic                     hit;

   // write and read the value memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      rd_data_ff <= value_mem[rd_addr];
   end

   // Issue order per pivot i: read i, then compare reads 0..n-1
   assign rd_addr = iss_piv_ff ? iss_i_ff : iss_j_ff;
   assign j_last  = (CntW'(iss_j_ff) + CntW'(1)) == n;
   assign i_last  = (CntW'(iss_i_ff) + CntW'(1)) == n;

   always_comb begin
      busy_in    = busy_ff;
      iss_piv_in = iss_piv_ff;
      iss_i_in   = iss_i_ff;
      iss_j_in   = iss_j_ff;
      if (start) begin
         busy_in    = 1'b1;
         iss_piv_in = 1'b1;
         iss_i_in   = '0;
      end else if (busy_ff) begin
         if (iss_piv_ff) begin
            iss_piv_in = 1'b0;
            iss_j_in   = '0;
         end else if (j_last) begin
            if (i_last) begin
               busy_in = 1'b0;
            end else begin
               iss_piv_in = 1'b1;
               iss_i_in   = iss_i_ff + IdxW'(1);
            end
         end else begin
            iss_j_in = iss_j_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         ret_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         ret_vld_ff <= busy_ff;
      end
      iss_piv_ff  <= iss_piv_in;
      iss_i_ff    <= iss_i_in;
      iss_j_ff    <= iss_j_in;
      ret_piv_ff  <= iss_piv_ff;
      ret_i_ff    <= iss_i_ff;
      ret_j_ff    <= iss_j_ff;
      ret_last_ff <= !iss_piv_ff && j_last;
      ret_done_ff <= !iss_piv_ff && j_last && i_last;
   end

   // Count elements ordered before the pivot; equal values keep input order
   assign hit = (rd_data_ff < pivot_ff) ||
                ((rd_data_ff == pivot_ff) && (ret_j_ff < ret_i_ff));
   assign rank_in = rank_ff + IdxW'(hit);

   always_ff @(posedge clock) begin
      if (ret_vld_ff && ret_piv_ff) begin
         pivot_ff <= rd_data_ff;
         rank_ff  <= '0;
      end else if (ret_vld_ff) begin
         rank_ff  <= rank_in;
      end
   end

   // Write the pivot index at its rank after its last compare
   assign ord_we   = ret_vld_ff && !ret_piv_ff && ret_last_ff;
   assign ord_addr = rank_in;
   assign ord_idx  = ret_i_ff;
   assign done     = ord_we && ret_done_ff;

endmodule : srs_rank

`default_nettype wire

// ----- src/srs_emit.sv -----
// Emit engine: holds the rank-to-index table in a synchronous memory and
// streams it out through a registered result stage. Depends on srs_pkg, srs_rsp_if.
`default_nettype none

module srs_emit
   import srs_pkg::*;
#(
   parameter int MAX_LEN = MaxLenDefault
) (
   input  wire                      clock,
   input  wire                      reset,
   // order table writes from the ranking engine
   input  wire                      ord_we,
   input  wire [$clog2(MAX_LEN)-1:0] ord_addr,
   input  wire [$clog2(MAX_LEN)-1:0] ord_idx,
   // emit control
   input  wire                      start,
   input  wire [$clog2(MAX_LEN+1)-1:0] n,
   input  wire                      dropped,
   output logic                     done,
   srs_rsp_if.source                rsp
);

   localparam int IdxW = $clog2(MAX_LEN);
   localparam int CntW = $clog2(MAX_LEN+1);

   // Order memory: written during ranking, read during emit only
   logic [IdxW-1:0] order_mem [MAX_LEN];
   logic [IdxW-1:0] rd_data_ff;

   logic            busy_ff;
   logic [IdxW-1:0] k_ff;
   logic            pend_ff;
   logic            pend_final_ff;
   logic            k_last;
   logic            out_free;
   logic            issue;

   logic               out_vld_ff;
   logic [SrcIdxW-1:0] out_idx_ff;
   logic               out_final_ff;
   logic               out_ovf_ff;

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_addr] <= ord_idx;
      end
      rd_data_ff <= order_mem[k_ff];
   end

   // Read the next rank only when the result stage will be free for it
   assign k_last   = (CntW'(k_ff) + CntW'(1)) == n;
   assign out_free = !out_vld_ff || rsp.ready;
   assign issue    = busy_ff && !pend_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (issue && k_last) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         k_ff <= '0;
      end else if (issue && !k_last) begin
         k_ff <= k_ff + IdxW'(1);
      end
      if (issue) begin
         pend_final_ff <= k_last;
      end
   end

   // Result stage: load returning data, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (pend_ff) begin
         out_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (pend_ff) begin
         out_idx_ff   <= SrcIdxW'(rd_data_ff);
         out_final_ff <= pend_final_ff;
         out_ovf_ff   <= dropped;
      end
   end

   assign done             = pend_ff && pend_final_ff;
   assign rsp.valid        = out_vld_ff;
   assign rsp.source_index = out_idx_ff;
   assign rsp.final_res    = out_final_ff;
   assign rsp.overflow     = out_ovf_ff;

endmodule : srs_emit

`default_nettype wire

// ----- src/stable_rank_sort_indices.sv -----
// Top level of the stable rank sort block: load controller, ranking engine
// and emit engine. Depends on srs_pkg, srs_req_if, srs_rsp_if, srs_rank, srs_emit.
//
//   channel   direction  carries
//   req_ch    in         value (signed Q16.16), is_last
//   rsp_ch    out        source_index, final_res, overflow
//
// Load takes one element per cycle. After the element marked last, ranking
// of the n held elements does one value-memory read per compare and one
// pivot read per element. Emit reads one rank at a time, the next only once
// the last is in the result register and that register is free. Ranking and
// emit take no element; a stalled result holds in its output register.
// Synchronous reset empties the set; memory contents are not cleared.
`default_nettype none

module stable_rank_sort_indices
   import srs_pkg::*;
#(
   parameter int MAX_LEN = MaxLenDefault
) (
   input  wire        clock,
   input  wire        reset,
   srs_req_if.sink    req_ch,
   srs_rsp_if.source  rsp_ch
);

   localparam int IdxW = $clog2(MAX_LEN);
   localparam int CntW = $clog2(MAX_LEN+1);

   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;

   logic            req_xfer;
   logic            has_room;
   logic            wr_en;
   logic            rank_start;
   logic            rank_done;
   logic            emit_done;
   logic            ord_we;
   logic [IdxW-1:0] ord_addr;
   logic [IdxW-1:0] ord_idx;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign has_room = count_ff < CntW'(MAX_LEN);
   assign wr_en    = req_xfer && has_room;

   // Phase control, element count and drop flag
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      req_ch.ready = 1'b0;
      rank_start   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_xfer) begin
               if (has_room) begin
                  count_in = count_ff + CntW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_ch.is_last) begin
                  rank_start = 1'b1;
                  state_in   = ST_RANK;
               end
            end
         end
         ST_RANK: begin
            if (rank_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   srs_rank #(
      .MAX_LEN (MAX_LEN)
   ) u_rank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IdxW-1:0]),
      .wr_value (req_ch.value),
      .start    (rank_start),
      .n        (count_ff),
      .ord_we   (ord_we),
      .ord_addr (ord_addr),
      .ord_idx  (ord_idx),
      .done     (rank_done)
   );

   srs_emit #(
      .MAX_LEN (MAX_LEN)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .ord_we   (ord_we),
      .ord_addr (ord_addr),
      .ord_idx  (ord_idx),
      .start    (rank_done),
      .n        (count_ff),
      .dropped  (dropped_ff),
      .done     (emit_done),
      .rsp      (rsp_ch)
   );

endmodule : stable_rank_sort_indices

`default_nettype wire

// ----- tb/stable_rank_sort_indices_tb.sv -----
// Testbench for stable_rank_sort_indices: loads sets of Q16.16 values and checks the
// emitted source indices against an in-bench stable counting-sort predictor.
// Depends on srs_pkg, srs_req_if, srs_rsp_if and the block's RTL.
`default_nettype none

module stable_rank_sort_indices_tb;
   import srs_pkg::*;

   localparam int MAX_LEN    = MaxLenDefault;
   localparam int IdleLimit  = 8000;
   localparam int DrainCycles = 2 * MAX_LEN + 16;
   localparam int NumRows    = 17;
   localparam int PhaseItems = 160;

   // One sorted-order entry as carried on the result channel
   typedef struct packed {
      logic [SrcIdxW-1:0] source_index;
      logic               final_res;
      logic               overflow;
   } order_entry_type;

   // Directed stimulus row; known is set where the result is typed in
   typedef struct {
      logic signed [ValueW-1:0] value;
      logic                     is_last;
      bit                       known;
      order_entry_type          known_res;
   } stim_row_type;

   logic clock;
   logic reset;

   srs_req_if req_if ();
   srs_rsp_if rsp_if ();

   stable_rank_sort_indices #(
      .MAX_LEN (MAX_LEN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Predictor state: the set being loaded and its drop flag
   logic signed [ValueW-1:0] set_values[$];
   bit                       set_dropped;
   order_entry_type          sorted_order_q[$];
   order_entry_type          oldest;

   bit failed;
   int src_idle_pct;
   int snk_stall_pct;
   int quiet_cycles;
   int items_sent;

   stim_row_type directed_rows [NumRows] = '{
      // single-element sets: index 0, final, no overflow
      '{32'h7FFF_FFFF, 1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
      '{32'h8000_0000, 1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
      '{32'h0000_0000, 1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
      // extremes mixed with zero and +/- one lsb
      '{32'h7FFF_FFFF, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h8000_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0000_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0000_0001, 1'b1, 1'b0, '{5'd0, 1'b0, 1'b0}},
      // ties must keep input order
      '{32'h0005_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'hFFFD_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0005_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0005_0000, 1'b1, 1'b0, '{5'd0, 1'b0, 1'b0}},
      // strictly descending
      '{32'h0003_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0002_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h0001_0000, 1'b1, 1'b0, '{5'd0, 1'b0, 1'b0}},
      // equal minimum values
      '{32'h8000_0000, 1'b0, 1'b0, '{5'd0, 1'b0, 1'b0}},
      '{32'h8000_0000, 1'b1, 1'b0, '{5'd0, 1'b0, 1'b0}}
   };

   // Store one accepted element; on the last one rank the set and queue its order
   task automatic take_element(input logic signed [ValueW-1:0] value, input logic is_last,
                               input bit known, input order_entry_type known_res);
      logic [SrcIdxW-1:0] index_at_rank [MAX_LEN];
      int                 rank;
      int                 count;
      if (set_values.size() < MAX_LEN) set_values.push_back(value);
      else set_dropped = 1'b1;
      if (!is_last) return;
      count = set_values.size();
      for (int i = 0; i < count; i++) begin
         rank = 0;
         for (int j = 0; j < count; j++) begin
            if (set_values[j] < set_values[i] || (set_values[j] == set_values[i] && j < i))
               rank++;
         end
         index_at_rank[rank] = i[SrcIdxW-1:0];
      end
      if (known) begin
         sorted_order_q.push_back(known_res);
      end else begin
         for (int k = 0; k < count; k++)
            sorted_order_q.push_back('{index_at_rank[k], k == count - 1, set_dropped});
      end
      set_values.delete();
      set_dropped = 1'b0;
   endtask

   // Present one element from a falling edge and hold it until the transfer
   task automatic send_element(input logic signed [ValueW-1:0] value, input logic is_last,
                               input bit known, input order_entry_type known_res);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.value   <= value;
      req_if.is_last <= is_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      take_element(value, is_last, known, known_res);
      items_sent++;
   endtask

   // Draw one element value: full range, extremes, or a narrow tie-heavy range
   function automatic logic signed [ValueW-1:0] pick_value(input int style);
      int step;
      case (style)
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: begin
            step = $urandom_range(0, 8);
            return (step - 4) * 65536;
         end
      endcase
   endfunction

   // Send random sets until the item goal is met; open with one overflowing set
   task automatic send_random_sets(input int item_goal);
      int goal;
      int len;
      int set_style;
      int style;
      goal = items_sent + item_goal;
      len  = MAX_LEN + $urandom_range(1, 4);
      while (items_sent < goal) begin
         set_style = $urandom_range(0, 3);
         for (int e = 0; e < len; e++) begin
            style = (set_style == 3) ? $urandom_range(0, 2) : set_style;
            send_element(pick_value(style), e == len - 1, 1'b0, '0);
         end
         case ($urandom_range(0, 99)) inside
            [0:74]:  len = $urandom_range(1, 8);
            [75:91]: len = $urandom_range(9, MAX_LEN - 1);
            [92:95]: len = MAX_LEN;
            default: len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
         endcase
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result sink: stall at random, changing at the falling edge
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   // Compare each result transfer with the oldest queued entry
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (sorted_order_q.size() == 0) begin
            $error("unexpected result: source_index %0d final_res %0b overflow %0b",
                   rsp_if.source_index, rsp_if.final_res, rsp_if.overflow);
            failed = 1'b1;
         end else begin
            oldest = sorted_order_q.pop_front();
            if (rsp_if.source_index !== oldest.source_index) begin
               $error("source_index: expected %0d, got %0d",
                      oldest.source_index, rsp_if.source_index);
               failed = 1'b1;
            end
            if (rsp_if.final_res !== oldest.final_res) begin
               $error("final_res: expected %0b, got %0b", oldest.final_res, rsp_if.final_res);
               failed = 1'b1;
            end
            if (rsp_if.overflow !== oldest.overflow) begin
               $error("overflow: expected %0b, got %0b", oldest.overflow, rsp_if.overflow);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("** stable_rank_sort_indices: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      set_dropped    = 1'b0;
      items_sent     = 0;
      src_idle_pct   = 15;
      snk_stall_pct  = 55;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      req_if.is_last = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows
      for (int r = 0; r < NumRows; r++)
         send_element(directed_rows[r].value, directed_rows[r].is_last,
                      directed_rows[r].known, directed_rows[r].known_res);

      // Random sets under three idle patterns
      send_random_sets(PhaseItems);
      src_idle_pct  = 55;
      snk_stall_pct = 15;
      send_random_sets(PhaseItems);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      send_random_sets(PhaseItems);

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sorted_order_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (!failed) begin
         $display("** stable_rank_sort_indices: PASSED **");
      end else begin
         $display("** stable_rank_sort_indices: FAILED **");
      end
      $finish;
   end

endmodule : stable_rank_sort_indices_tb

`default_nettype wire
